>>> hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kind codes, keyword patterns, character codes and the queue size.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	// token kind codes as they leave the block
	typedef enum logic [4:0] {
		TOK_EOF     = 5'd0,
		TOK_IDENT   = 5'd1,
		TOK_NUMBER  = 5'd2,
		TOK_UNKNOWN = 5'd3,
		TOK_FN      = 5'd4,
		TOK_IF      = 5'd5,
		TOK_ELSE    = 5'd6,
		TOK_LET     = 5'd7,
		TOK_BOOLEAN = 5'd8,
		TOK_PLUS    = 5'd9,
		TOK_MINUS   = 5'd10,
		TOK_ARROW   = 5'd11,
		TOK_MUL     = 5'd12,
		TOK_DIV     = 5'd13,
		TOK_LPAREN  = 5'd14,
		TOK_RPAREN  = 5'd15,
		TOK_COMMA   = 5'd16,
		TOK_LCURLY  = 5'd17,
		TOK_RCURLY  = 5'd18,
		TOK_ASSIGN  = 5'd19,
		TOK_COLON   = 5'd20
	} tok_kind_t;

	localparam int KIND_W = 5;

	// first five identifier bytes, first byte in the low bits
	localparam int KW_W = 40;
	localparam logic [KW_W-1:0] KW_FN    = 40'h00_0000_6E66;
	localparam logic [KW_W-1:0] KW_IF    = 40'h00_0000_6669;
	localparam logic [KW_W-1:0] KW_ELSE  = 40'h00_6573_6C65;
	localparam logic [KW_W-1:0] KW_LET   = 40'h00_0074_656C;
	localparam logic [KW_W-1:0] KW_TRUE  = 40'h00_6575_7274;
	localparam logic [KW_W-1:0] KW_FALSE = 40'h65_736C_6166;

	// character codes with a role of their own
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_MINUS      = 8'h2D;

	// token queue between scanner and output stage (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// which of the two token slots an accepted transaction fills
	typedef struct packed {
		logic v0;
		logic v1;
	} push_t;

endpackage

`default_nettype wire

>>> hdl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: character scanner
// Classifies each character, tracks the open token and emits up to two
// tokens per transaction (a closed or arrow token, then a single-character
// or eof token).
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
	parameter int POSITION_BITS = 32,
	parameter int LENGTH_BITS   = 16,
	parameter int ENT_W         = 5 + POSITION_BITS + LENGTH_BITS + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic              is_end,
	input  wire logic [7:0]        char_code,
	output stt_pkg::push_t         push,
	output logic [ENT_W-1:0]       tok0,
	output logic [ENT_W-1:0]       tok1
);
	import stt_pkg::*;

	localparam int P = POSITION_BITS;
	localparam int L = LENGTH_BITS;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_IDENT = 3'd1,
		MODE_WHOLE = 3'd2,
		MODE_FRAC  = 3'd3,
		MODE_MINUS = 3'd4
	} mode_t;

	mode_t             mode_q, mode_d;
	logic [P-1:0]      start_q, start_d;
	logic [L-1:0]      len_q, len_d;
	logic [KW_W-1:0]   kw_q, kw_d;
	logic [P-1:0]      pos_q, pos_d;

	logic              is_letter, is_digit, is_space, is_ident_start, is_ident_c;
	logic              open_tok;
	tok_kind_t         flush_kind, id_kind, sym_kind;
	logic [L-1:0]      flush_len;
	logic              taken, ext, opening;
	mode_t             open_mode;
	tok_kind_t         k0, k1;
	logic [P-1:0]      s0, s1;
	logic [L-1:0]      l0, l1;
	logic              v0, v1;

	// character classes
	always_comb begin
		is_letter      = (char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]});
		is_digit       = (char_code inside {[8'h30:8'h39]});
		is_space       = (char_code inside {8'h20, [8'h09:8'h0D]});
		is_ident_start = is_letter || (char_code == CH_UNDERSCORE);
		is_ident_c     = is_ident_start || is_digit;
	end

	// single-character symbols
	always_comb begin
		case (char_code)
			8'h2B:   sym_kind = TOK_PLUS;
			8'h2A:   sym_kind = TOK_MUL;
			8'h2F:   sym_kind = TOK_DIV;
			8'h28:   sym_kind = TOK_LPAREN;
			8'h29:   sym_kind = TOK_RPAREN;
			8'h2C:   sym_kind = TOK_COMMA;
			8'h7B:   sym_kind = TOK_LCURLY;
			8'h7D:   sym_kind = TOK_RCURLY;
			8'h3D:   sym_kind = TOK_ASSIGN;
			8'h3A:   sym_kind = TOK_COLON;
			default: sym_kind = TOK_UNKNOWN;
		endcase
	end

	// keyword match on the open identifier
	always_comb begin
		if (len_q == L'(2) && kw_q == KW_FN)         id_kind = TOK_FN;
		else if (len_q == L'(2) && kw_q == KW_IF)    id_kind = TOK_IF;
		else if (len_q == L'(4) && kw_q == KW_ELSE)  id_kind = TOK_ELSE;
		else if (len_q == L'(3) && kw_q == KW_LET)   id_kind = TOK_LET;
		else if (len_q == L'(4) && kw_q == KW_TRUE)  id_kind = TOK_BOOLEAN;
		else if (len_q == L'(5) && kw_q == KW_FALSE) id_kind = TOK_BOOLEAN;
		else                                         id_kind = TOK_IDENT;
	end

	// token that closes the open run
	always_comb begin
		open_tok   = 1'b1;
		flush_kind = TOK_NUMBER;
		flush_len  = len_q;
		case (mode_q)
			MODE_IDENT: flush_kind = id_kind;
			MODE_WHOLE: flush_kind = TOK_NUMBER;
			MODE_FRAC:  flush_kind = TOK_NUMBER;
			MODE_MINUS: begin
				flush_kind = TOK_MINUS;
				flush_len  = L'(1);
			end
			default:    open_tok = 1'b0;
		endcase
	end

	// next state and emitted tokens
	always_comb begin
		mode_d    = mode_q;
		start_d   = start_q;
		len_d     = len_q;
		kw_d      = kw_q;
		pos_d     = pos_q;
		v0        = 1'b0;
		v1        = 1'b0;
		k0        = flush_kind;
		s0        = start_q;
		l0        = flush_len;
		k1        = TOK_EOF;
		s1        = pos_q;
		l1        = '0;
		taken     = 1'b0;
		ext       = 1'b0;
		opening   = 1'b0;
		open_mode = MODE_IDLE;
		if (is_end) begin
			v0      = open_tok;
			v1      = 1'b1;
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
			len_d   = '0;
			kw_d    = '0;
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_ident_c) begin
						ext   = 1'b1;
						taken = 1'b1;
					end
				end
				MODE_WHOLE: begin
					if (is_digit) begin
						ext   = 1'b1;
						taken = 1'b1;
					end else if (char_code == CH_DOT) begin
						ext    = 1'b1;
						taken  = 1'b1;
						mode_d = MODE_FRAC;
					end
				end
				MODE_FRAC: begin
					if (is_digit) begin
						ext   = 1'b1;
						taken = 1'b1;
					end
				end
				MODE_MINUS: begin
					if (char_code == CH_GT) begin
						v0     = 1'b1;
						k0     = TOK_ARROW;
						l0     = L'(2);
						mode_d = MODE_IDLE;
						taken  = 1'b1;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
			if (!taken) begin
				v0     = open_tok;
				mode_d = MODE_IDLE;
				if (is_space) begin
					opening = 1'b0;
				end else if (is_ident_start) begin
					opening   = 1'b1;
					open_mode = MODE_IDENT;
				end else if (is_digit) begin
					opening   = 1'b1;
					open_mode = MODE_WHOLE;
				end else if (char_code == CH_DOT) begin
					opening   = 1'b1;
					open_mode = MODE_FRAC;
				end else if (char_code == CH_MINUS) begin
					opening   = 1'b1;
					open_mode = MODE_MINUS;
				end else begin
					v1 = 1'b1;
					k1 = sym_kind;
					l1 = L'(1);
				end
				if (opening) begin
					mode_d  = open_mode;
					start_d = pos_q;
					len_d   = L'(1);
					kw_d    = {{(KW_W-8){1'b0}}, char_code};
				end
			end
			if (ext) begin
				if (len_q < L'(5))
					kw_d = kw_q | ({{(KW_W-8){1'b0}}, char_code} << {len_q[2:0], 3'b000});
				if (len_q != '1)
					len_d = len_q + L'(1);
			end
			pos_d = pos_q + P'(1);
		end
	end

	// token slots, the later one of a transaction carries the last flag
	assign push.v0 = take && v0;
	assign push.v1 = take && v1;
	assign tok0    = {k0, s0, l0, !v1};
	assign tok1    = {k1, s1, l1, 1'b1};

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			kw_q    <= '0;
			pos_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			kw_q    <= kw_d;
			pos_q   <= pos_d;
		end
	end

`ifndef ASSERT_OFF
	// end of source restarts the position and closes any open token
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_end |=> pos_q == '0 && mode_q == MODE_IDLE)
		else $error("position or mode not cleared after end of source");
	// every character advances the position by one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !is_end |=> pos_q == P'($past(pos_q) + P'(1)))
		else $error("position did not advance");
`endif

endmodule

`default_nettype wire

>>> hdl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue: token queue
// Small queue of tokens that takes up to two entries per cycle from the
// scanner and hands out one per cycle to the output stage while it is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue #(
	parameter int ENT_W = 54
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  stt_pkg::push_t         push,
	input  wire logic [ENT_W-1:0]  ent0,
	input  wire logic [ENT_W-1:0]  ent1,
	output logic                   room,
	output logic                   head_valid,
	output logic [ENT_W-1:0]       head,
	input  wire logic              pop_ready
);
	import stt_pkg::*;

	logic [ENT_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       n_push;
	logic             pop;
	logic [ENT_W-1:0] first;

	// two free entries are needed for a transaction that may bring two tokens
	assign room       = count_q <= CNT_W'(QUEUE_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];
	assign pop        = pop_ready && head_valid;
	assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
	assign first      = push.v0 ? ent0 : ent1;

	// entry storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_q] <= first;
		if (n_push == 2'd2)
			mem_q[wr_q + PTR_W'(1)] <= ent1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	// fill count stays within the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("token queue count out of range");
	// a push never overruns the queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		n_push != 2'd0 |-> ({1'b0, count_q} + (CNT_W+1)'(n_push))
			<= (CNT_W+1)'(QUEUE_DEPTH))
		else $error("token queue overrun");
`endif

endmodule

`default_nettype wire

>>> hdl/stt_out_stage.sv
// ----------------------------------------------------------------------------
// stt_out_stage: output register
// Holds the token on the master side while the queue refills behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_out_stage #(
	parameter int ENT_W = 54
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ENT_W-1:0]  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ENT_W-1:0]       out_data
);
	logic             valid_q;
	logic [ENT_W-1:0] data_q;

	// load when empty or when the held token leaves this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_q <= in_data;
	end

endmodule

`default_nettype wire

>>> hdl/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: streaming source tokenizer
// Turns a character stream into tokens (kind, start offset, length).
//
//   channel  dir  tdata                           tuser            tlast
//   s_axis   in   char_code[7:0]                  kind (1=end)     -
//   m_axis   out  start_offset, token_length,pad  token_kind[4:0]  last_of_run
//
// One character per cycle is taken while the token queue has two free
// entries; the scanner settles each character in the cycle it is accepted.
// A transaction yields at most two tokens; the output drains one token per
// cycle while m_axis_tready is high, so inputs that give two tokens each are
// not taken every cycle; tokens pass the queue, then the output register.
// Reset clears the scanner, queue and output register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_core #(
	parameter int POSITION_BITS = 32,
	parameter int LENGTH_BITS   = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,   // char_code[7:0]
	input  wire logic              s_axis_tuser,   // kind
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [((POSITION_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0]
	                               m_axis_tdata,   // start_offset, token_length, zero pad
	output stt_pkg::tok_kind_t     m_axis_tuser,   // token_kind
	output logic                   m_axis_tlast    // last_of_run
);
	import stt_pkg::*;

	localparam int P      = POSITION_BITS;
	localparam int L      = LENGTH_BITS;
	localparam int ENT_W  = KIND_W + P + L + 1;
	localparam int DATA_W = ((P + L + 7) / 8) * 8;

	push_t            push;
	logic [ENT_W-1:0] tok0, tok1;
	logic             room, head_valid, pop_ready;
	logic [ENT_W-1:0] head, out_ent;
	logic             take;

	// input transaction
	assign s_axis_tready = room;
	assign take          = s_axis_tvalid && room;

	stt_front #(
		.POSITION_BITS (P),
		.LENGTH_BITS   (L),
		.ENT_W         (ENT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.is_end    (s_axis_tuser),
		.char_code (s_axis_tdata),
		.push      (push),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	stt_queue #(
		.ENT_W (ENT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.ent0       (tok0),
		.ent1       (tok1),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop_ready  (pop_ready)
	);

	stt_out_stage #(
		.ENT_W (ENT_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (head_valid),
		.in_ready  (pop_ready),
		.in_data   (head),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_ent)
	);

	// unpack kind, start, length, last
	assign m_axis_tuser = tok_kind_t'(out_ent[ENT_W-1 -: KIND_W]);
	assign m_axis_tlast = out_ent[0];
	assign m_axis_tdata = DATA_W'({out_ent[L:1], out_ent[P+L:L+1]});

endmodule

`default_nettype wire

>>> sim/source_text_tokenizer_core_tb.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_tb: self-checking bench of the source tokenizer
// Streams characters and end-of-source items into the tokenizer, predicts
// every token from a scanner model of its own and checks the token stream
// field by field, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_core_tb;

	import stt_pkg::*;

	localparam int POS_W  = 32;
	localparam int LEN_W  = 16;
	localparam int DATA_W = 48;

	// scanner modes of the predictor
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_IDENT,
		SCAN_WHOLE,
		SCAN_FRAC,
		SCAN_MINUS
	} scan_t;

	typedef struct packed {
		logic       at_end;
		logic [7:0] ch;
	} source_item_t;

	typedef struct packed {
		tok_kind_t        kind;
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic             last;
	} token_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0;   // char_code[7:0]
	logic              s_axis_tuser  = 1'b0; // kind
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;         // start_offset[31:0], token_length[47:32]
	tok_kind_t         m_axis_tuser;         // token_kind
	logic              m_axis_tlast;         // last_of_run

	source_item_t source_items[$];
	token_t       expected_tokens[$];

	// predictor state
	scan_t            mode      = SCAN_IDLE;
	logic [POS_W-1:0] open_start = '0;
	logic [LEN_W-1:0] open_len   = '0;
	logic [39:0]      kw_bytes   = '0;
	logic [POS_W-1:0] position   = '0;

	int items_taken = 0;
	int errors      = 0;
	int src_gap     = 0;
	int sink_gap    = 0;
	int hold_at     = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;

	source_text_tokenizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// character classes
	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void emit(input tok_kind_t k, input logic [POS_W-1:0] s,
			input logic [LEN_W-1:0] l);
		token_t t;
		t.kind  = k;
		t.start = s;
		t.len   = l;
		t.last  = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	// append a character to the open token, keeping the keyword bytes
	function automatic void extend(input logic [7:0] c);
		if (open_len < 5)
			kw_bytes = kw_bytes | (40'(c) << (8 * open_len));
		if (open_len != {LEN_W{1'b1}})
			open_len = open_len + 1'b1;
	endfunction

	function automatic void open_token(input scan_t m, input logic [7:0] c);
		mode       = m;
		open_start = position;
		open_len   = '0;
		kw_bytes   = '0;
		extend(c);
	endfunction

	function automatic tok_kind_t word_kind();
		if (open_len == 2 && kw_bytes == KW_FN)    return TOK_FN;
		if (open_len == 2 && kw_bytes == KW_IF)    return TOK_IF;
		if (open_len == 4 && kw_bytes == KW_ELSE)  return TOK_ELSE;
		if (open_len == 3 && kw_bytes == KW_LET)   return TOK_LET;
		if (open_len == 4 && kw_bytes == KW_TRUE)  return TOK_BOOLEAN;
		if (open_len == 5 && kw_bytes == KW_FALSE) return TOK_BOOLEAN;
		return TOK_IDENT;
	endfunction

	// close whatever token is open
	function automatic void flush_open();
		case (mode)
			SCAN_IDENT: emit(word_kind(), open_start, open_len);
			SCAN_WHOLE, SCAN_FRAC: emit(TOK_NUMBER, open_start, open_len);
			SCAN_MINUS: emit(TOK_MINUS, open_start, LEN_W'(1));
			default: ;
		endcase
		mode = SCAN_IDLE;
	endfunction

	// a character seen with nothing open
	function automatic void begin_token(input logic [7:0] c);
		tok_kind_t k;
		if (is_space(c)) return;
		if (is_letter(c) || c == CH_UNDERSCORE) begin
			open_token(SCAN_IDENT, c);
			return;
		end
		if (is_digit(c)) begin
			open_token(SCAN_WHOLE, c);
			return;
		end
		if (c == CH_DOT) begin
			open_token(SCAN_FRAC, c);
			return;
		end
		if (c == CH_MINUS) begin
			open_token(SCAN_MINUS, c);
			return;
		end
		case (c)
			"+": k = TOK_PLUS;
			"*": k = TOK_MUL;
			"/": k = TOK_DIV;
			"(": k = TOK_LPAREN;
			")": k = TOK_RPAREN;
			",": k = TOK_COMMA;
			"{": k = TOK_LCURLY;
			"}": k = TOK_RCURLY;
			"=": k = TOK_ASSIGN;
			":": k = TOK_COLON;
			default: k = TOK_UNKNOWN;
		endcase
		emit(k, position, LEN_W'(1));
	endfunction

	// expected tokens of one accepted input transaction
	function automatic void tokenize_item(input source_item_t it);
		int     n;
		bit     taken;
		token_t t;
		n     = expected_tokens.size();
		taken = 1'b0;
		if (it.at_end) begin
			flush_open();
			emit(TOK_EOF, position, '0);
			position   = '0;
			open_start = '0;
			open_len   = '0;
			kw_bytes   = '0;
		end else begin
			case (mode)
				SCAN_IDENT: begin
					if (is_letter(it.ch) || is_digit(it.ch) || it.ch == CH_UNDERSCORE) begin
						extend(it.ch);
						taken = 1'b1;
					end
				end
				SCAN_WHOLE: begin
					if (is_digit(it.ch)) begin
						extend(it.ch);
						taken = 1'b1;
					end else if (it.ch == CH_DOT) begin
						extend(it.ch);
						mode  = SCAN_FRAC;
						taken = 1'b1;
					end
				end
				SCAN_FRAC: begin
					if (is_digit(it.ch)) begin
						extend(it.ch);
						taken = 1'b1;
					end
				end
				SCAN_MINUS: begin
					if (it.ch == CH_GT) begin
						emit(TOK_ARROW, open_start, LEN_W'(2));
						mode  = SCAN_IDLE;
						taken = 1'b1;
					end
				end
				default: mode = SCAN_IDLE;
			endcase
			if (!taken) begin
				flush_open();
				begin_token(it.ch);
			end
			position = position + 1'b1;
		end
		// mark the last token of this transaction
		if (expected_tokens.size() > n) begin
			t = expected_tokens[expected_tokens.size() - 1];
			t.last = 1'b1;
			expected_tokens[expected_tokens.size() - 1] = t;
		end
	endfunction

	// stimulus builders
	function automatic void push_char(input logic [7:0] c);
		source_items.push_back({1'b0, c});
	endfunction

	function automatic void push_end(input logic [7:0] c);
		source_items.push_back({1'b1, c});
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endfunction

	function automatic logic [7:0] rand_ident_char();
		case ($urandom_range(0, 3))
			0: return 8'("a") + 8'($urandom_range(0, 25));
			1: return 8'("A") + 8'($urandom_range(0, 25));
			2: return 8'("0") + 8'($urandom_range(0, 9));
			default: return CH_UNDERSCORE;
		endcase
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0") + 8'($urandom_range(0, 9));
	endfunction

	// one well-formed lexeme with random content, then maybe whitespace
	function automatic void add_random_lexeme();
		string       words[6];
		string       syms;
		logic [7:0]  spaces[6];
		string       w;
		int          n;
		words  = '{"fn", "if", "else", "let", "true", "false"};
		syms   = "+*/(),{}=:";
		spaces = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		case ($urandom_range(0, 9))
			0, 1: begin
				w = words[$urandom_range(0, 5)];
				case ($urandom_range(0, 3))
					0: push_text(w.substr(0, w.len() - 2));
					1: begin
						push_text(w);
						push_char(rand_ident_char());
					end
					default: push_text(w);
				endcase
			end
			2, 3: begin
				if ($urandom_range(0, 3) == 0)
					push_char(CH_UNDERSCORE);
				else
					push_char(($urandom_range(0, 1) ? 8'("a") : 8'("A"))
						+ 8'($urandom_range(0, 25)));
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++)
					push_char(rand_ident_char());
			end
			4, 5: begin
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					push_char(rand_digit());
				if (n == 0 || $urandom_range(0, 1)) begin
					push_char(CH_DOT);
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++)
						push_char(rand_digit());
				end
			end
			6: begin
				push_char(CH_MINUS);
				if ($urandom_range(0, 2) != 0)
					push_char(CH_GT);
			end
			7, 8: push_char(syms[$urandom_range(0, syms.len() - 1)]);
			default: begin
				// broken arrow or minus before a number
				push_char(CH_MINUS);
				if ($urandom_range(0, 1)) begin
					push_char(spaces[$urandom_range(0, 5)]);
					push_char(CH_GT);
				end else begin
					push_char(rand_digit());
				end
			end
		endcase
		if ($urandom_range(0, 9) < 6) begin
			n = $urandom_range(1, 2);
			for (int i = 0; i < n; i++)
				push_char(spaces[$urandom_range(0, 5)]);
		end
	endfunction

	// idling allowed outside quiet stretches and the closing part
	function automatic bit may_idle();
		return source_items.size() > 250 && ((items_taken >> 8) % 3) != 0;
	endfunction

	// input driver: offers the head of the pending queue
	always @(posedge clk or negedge arst_n) begin : source_drive
		bit offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				tokenize_item(source_items.pop_front());
				items_taken = items_taken + 1;
				offer = 1'b0;
			end
			if (!offer) begin
				if (src_gap > 0)
					src_gap = src_gap - 1;
				else if (may_idle() && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(0, 3);
				else if (source_items.size() != 0)
					offer = 1'b1;
			end
			s_axis_tvalid <= offer;
			if (offer) begin
				s_axis_tdata <= source_items[0].ch;
				s_axis_tuser <= source_items[0].at_end;
			end
		end
	end

	// long output hold-off, once, while input keeps coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_taken >= hold_at) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output monitor: checks each token transaction, drives ready
	always @(posedge clk or negedge arst_n) begin : token_check
		token_t want;
		bit     rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d offset %0d length %0d",
						m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32]);
					errors = errors + 1;
				end else begin
					want = expected_tokens.pop_front();
					if (m_axis_tuser !== want.kind) begin
						$error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
						errors = errors + 1;
					end
					if (m_axis_tdata[31:0] !== want.start) begin
						$error("start_offset: expected %0d, actual %0d",
							want.start, m_axis_tdata[31:0]);
						errors = errors + 1;
					end
					if (m_axis_tdata[47:32] !== want.len) begin
						$error("token_length: expected %0d, actual %0d",
							want.len, m_axis_tdata[47:32]);
						errors = errors + 1;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_of_run: expected %0d, actual %0d", want.last, m_axis_tlast);
						errors = errors + 1;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap = sink_gap - 1;
				rdy = 1'b0;
			end else if (may_idle() && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 3);
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_axis_tready <= rdy && (hold_left == 0);
		end
	end

	// stimulus, reset and end of run
	initial begin
		int base;
		int r;
		// keyword, arrow, minus, numbers with dots, every symbol, unknown bytes
		push_text("fn->-x 9.5.+*/(),{}=:");
		push_char(8'h80);
		push_char(8'hFF);
		push_char(8'h00);
		push_end(8'h41);   // nothing open after the unknown bytes: eof only
		push_end(8'hC3);   // nothing open: eof only
		// identifier far longer than any keyword
		push_char(CH_UNDERSCORE);
		for (int i = 0; i < 40; i++)
			push_char(rand_ident_char());
		push_char(8'h20);
		hold_at = source_items.size() + 150;
		// random source text, mostly well formed
		base = source_items.size();
		while (source_items.size() - base < 1850) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				push_char(8'($urandom_range(0, 255)));
			else if (r < 10)
				push_end(8'($urandom_range(0, 255)));
			else
				add_random_lexeme();
		end
		push_end(8'($urandom_range(0, 255)));

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (source_items.size() != 0 || expected_tokens.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("source_text_tokenizer_core_tb: PASS");
		else
			$display("source_text_tokenizer_core_tb: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("source_text_tokenizer_core_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_out_stage.sv
hdl/source_text_tokenizer_core.sv
sim/source_text_tokenizer_core_tb.sv
